// ----- rtl/bec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types and codes for the bipartite edge coloring block.
// ----------------------------------------------------------------------------
package bec_pkg;

  typedef logic [4:0] op_t;

  // datapath operations, one per cycle
  localparam op_t OP_NONE   = 5'd0;
  localparam op_t OP_CLR    = 5'd1;
  localparam op_t OP_LOAD   = 5'd2;
  localparam op_t OP_CHECK  = 5'd3;
  localparam op_t OP_RD_ISS = 5'd4;
  localparam op_t OP_RD_RES = 5'd5;
  localparam op_t OP_LS_ISS = 5'd6;
  localparam op_t OP_LS_CHK = 5'd7;
  localparam op_t OP_RS_ISS = 5'd8;
  localparam op_t OP_RS_CHK = 5'd9;
  localparam op_t OP_P_ISS  = 5'd10;
  localparam op_t OP_P_LOAD = 5'd11;
  localparam op_t OP_ST_ISS = 5'd12;
  localparam op_t OP_ST_W1  = 5'd13;
  localparam op_t OP_ST_W2  = 5'd14;
  localparam op_t OP_FIN    = 5'd15;
  localparam op_t OP_EMIT   = 5'd16;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_LEFT_FULL  = 2'd1;
  localparam logic [1:0] ST_RIGHT_FULL = 2'd2;
  localparam logic [1:0] ST_RANGE      = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_COLOR_COUNT  = 1'b1;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_read;
    logic early_exit;  // range error, or insert with no colors
    logic free_l;
    logic free_r;
    logic scan_last;
    logic path_go;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/bec_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bec_ctrl
// Sequencer: clearing pass, free-color scans, path walk, result hand-off.
// ----------------------------------------------------------------------------
module bec_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire bec_pkg::sts_t sts,
  output bec_pkg::cmd_t     cmd
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CHECK  = 5'd2;
  localparam logic [4:0] S_RD_ISS = 5'd3;
  localparam logic [4:0] S_RD_RES = 5'd4;
  localparam logic [4:0] S_LS_ISS = 5'd5;
  localparam logic [4:0] S_LS_CHK = 5'd6;
  localparam logic [4:0] S_RS_ISS = 5'd7;
  localparam logic [4:0] S_RS_CHK = 5'd8;
  localparam logic [4:0] S_P_ISS  = 5'd9;
  localparam logic [4:0] S_P_LOAD = 5'd10;
  localparam logic [4:0] S_P_TEST = 5'd11;
  localparam logic [4:0] S_ST_ISS = 5'd12;
  localparam logic [4:0] S_ST_W1  = 5'd13;
  localparam logic [4:0] S_ST_W2  = 5'd14;
  localparam logic [4:0] S_FIN    = 5'd15;
  localparam logic [4:0] S_EMIT   = 5'd16;

  logic [4:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = bec_pkg::OP_NONE;
    unique case (state_r)
      S_CLR: begin
        cmd.op = bec_pkg::OP_CLR;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = bec_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = bec_pkg::OP_CHECK;
        if (sts.early_exit)   state_nxt = S_EMIT;
        else if (sts.is_read) state_nxt = S_RD_ISS;
        else                  state_nxt = S_LS_ISS;
      end
      S_RD_ISS: begin
        cmd.op    = bec_pkg::OP_RD_ISS;
        state_nxt = S_RD_RES;
      end
      S_RD_RES: begin
        cmd.op    = bec_pkg::OP_RD_RES;
        state_nxt = S_EMIT;
      end
      S_LS_ISS: begin
        cmd.op    = bec_pkg::OP_LS_ISS;
        state_nxt = S_LS_CHK;
      end
      S_LS_CHK: begin
        cmd.op = bec_pkg::OP_LS_CHK;
        if (sts.free_l)         state_nxt = S_RS_ISS;
        else if (sts.scan_last) state_nxt = S_EMIT;
        else                    state_nxt = S_LS_ISS;
      end
      S_RS_ISS: begin
        cmd.op    = bec_pkg::OP_RS_ISS;
        state_nxt = S_RS_CHK;
      end
      S_RS_CHK: begin
        cmd.op = bec_pkg::OP_RS_CHK;
        if (sts.free_r)         state_nxt = S_P_ISS;
        else if (sts.scan_last) state_nxt = S_EMIT;
        else                    state_nxt = S_RS_ISS;
      end
      S_P_ISS: begin
        cmd.op    = bec_pkg::OP_P_ISS;
        state_nxt = S_P_LOAD;
      end
      S_P_LOAD: begin
        cmd.op    = bec_pkg::OP_P_LOAD;
        state_nxt = S_P_TEST;
      end
      S_P_TEST: begin
        state_nxt = sts.path_go ? S_ST_ISS : S_FIN;
      end
      S_ST_ISS: begin
        cmd.op    = bec_pkg::OP_ST_ISS;
        state_nxt = S_ST_W1;
      end
      S_ST_W1: begin
        cmd.op    = bec_pkg::OP_ST_W1;
        state_nxt = S_ST_W2;
      end
      S_ST_W2: begin
        cmd.op    = bec_pkg::OP_ST_W2;
        state_nxt = S_P_TEST;
      end
      S_FIN: begin
        cmd.op    = bec_pkg::OP_FIN;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = bec_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/bec_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bec_dp
// Datapath: partner tables, scan and path registers, result register.
// ----------------------------------------------------------------------------
module bec_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_COLORS   = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bec_pkg::cmd_t cmd,
  output bec_pkg::sts_t      sts,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [6:0]    cfg_data,
  input  wire logic          in_action,
  input  wire logic [5:0]    in_left_vertex,
  input  wire logic [5:0]    in_right_vertex,
  input  wire logic [5:0]    in_read_color,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [5:0]         out_assigned_color,
  output logic [5:0]         out_partner,
  output logic               out_partner_valid,
  output logic [7:0]         out_recolored_edges
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int DEPTH = MAX_VERTICES * MAX_COLORS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NV_W  = $clog2(MAX_VERTICES + 1);
  localparam int NC_W  = $clog2(MAX_COLORS + 1);
  localparam int NW0   = (NV_W > NC_W) ? NV_W : NC_W;
  localparam int NW    = (NW0 > 7) ? NW0 : 7;
  localparam int PATH_LIMIT = 2 * MAX_VERTICES;
  localparam int SW    = $clog2(PATH_LIMIT + 1);
  localparam int EW    = VW + 1;

  function automatic logic [AW-1:0] slot(input logic [VW-1:0] v, input logic [CW-1:0] c);
    return AW'(AW'(v) * AW'(MAX_COLORS)) + AW'(c);
  endfunction

  // tables: entry = {ok, who}
  logic [EW-1:0] lt_mem [DEPTH];
  logic [EW-1:0] rt_mem [DEPTH];
  logic [EW-1:0] lt_rd_r, rt_rd_r;
  logic          lt_re, rt_re, lt_we, rt_we;
  logic [AW-1:0] lt_ra, rt_ra, lt_wa, rt_wa;
  logic [EW-1:0] lt_wd, rt_wd;

  logic [6:0]    vcnt_r, ccnt_r;
  logic [AW-1:0] clr_r;
  logic          act_r;
  logic [5:0]    lv_r, rv_r, rc_r;
  logic [CW-1:0] scan_r, alpha_r, beta_r;
  logic [VW-1:0] cur_r, nxt_r, nn_r;
  logic          nxt_ok_r, nn_ok_r, at_left_r;
  logic [SW-1:0] steps_r;
  logic [1:0]    res_status_r;
  logic [5:0]    res_color_r, res_partner_r;
  logic          res_pvalid_r;
  logic [7:0]    res_edges_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [5:0]    out_color_r, out_partner_r;
  logic          out_pvalid_r;
  logic [7:0]    out_edges_r;

  logic [NW-1:0] nv, nc;
  logic [VW-1:0] v_i, w_i;
  logic          range_bad;
  logic [EW-1:0] nn_src;

  assign nv  = (NW'(vcnt_r) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcnt_r);
  assign nc  = (NW'(ccnt_r) > NW'(MAX_COLORS))   ? NW'(MAX_COLORS)   : NW'(ccnt_r);
  assign v_i = VW'(lv_r);
  assign w_i = VW'(rv_r);

  assign range_bad = (act_r == bec_pkg::ACT_READ)
                   ? ((NW'(lv_r) >= nv) || (NW'(rc_r) >= nc))
                   : ((NW'(lv_r) >= nv) || (NW'(rv_r) >= nv));

  assign nn_src = at_left_r ? lt_rd_r : rt_rd_r;

  assign sts.clr_done   = (clr_r == AW'(DEPTH - 1));
  assign sts.is_read    = (act_r == bec_pkg::ACT_READ);
  assign sts.early_exit = range_bad || ((act_r == bec_pkg::ACT_INSERT) && (nc == '0));
  assign sts.free_l     = !lt_rd_r[VW];
  assign sts.free_r     = !rt_rd_r[VW];
  assign sts.scan_last  = ((NW'(scan_r) + NW'(1)) >= nc);
  assign sts.path_go    = nxt_ok_r && (steps_r < SW'(PATH_LIMIT));
  assign sts.out_free   = !out_valid_r || !out_stall;

  // table port selection
  always_comb begin
    lt_re = 1'b0; lt_ra = '0; lt_we = 1'b0; lt_wa = '0; lt_wd = '0;
    rt_re = 1'b0; rt_ra = '0; rt_we = 1'b0; rt_wa = '0; rt_wd = '0;
    unique case (cmd.op)
      bec_pkg::OP_CLR: begin
        lt_we = 1'b1; lt_wa = clr_r;
        rt_we = 1'b1; rt_wa = clr_r;
      end
      bec_pkg::OP_RD_ISS: begin
        lt_re = 1'b1; lt_ra = slot(v_i, CW'(rc_r));
      end
      bec_pkg::OP_LS_ISS: begin
        lt_re = 1'b1; lt_ra = slot(v_i, scan_r);
      end
      bec_pkg::OP_RS_ISS: begin
        rt_re = 1'b1; rt_ra = slot(w_i, scan_r);
      end
      bec_pkg::OP_P_ISS: begin
        rt_re = 1'b1; rt_ra = slot(w_i, alpha_r);
      end
      bec_pkg::OP_ST_ISS: begin
        if (at_left_r) begin
          lt_re = 1'b1; lt_ra = slot(nxt_r, beta_r);
        end else begin
          rt_re = 1'b1; rt_ra = slot(nxt_r, alpha_r);
        end
      end
      bec_pkg::OP_ST_W1: begin
        lt_we = 1'b1; rt_we = 1'b1;
        if (at_left_r) begin
          lt_wa = slot(nxt_r, beta_r); lt_wd = {1'b1, cur_r};
          rt_wa = slot(cur_r, beta_r); rt_wd = {1'b1, nxt_r};
        end else begin
          rt_wa = slot(nxt_r, alpha_r); rt_wd = {1'b1, cur_r};
          lt_wa = slot(cur_r, alpha_r); lt_wd = {1'b1, nxt_r};
        end
      end
      bec_pkg::OP_ST_W2: begin
        if (at_left_r) begin
          lt_we = 1'b1; lt_wa = slot(nxt_r, alpha_r);
        end else begin
          rt_we = 1'b1; rt_wa = slot(nxt_r, beta_r);
        end
      end
      bec_pkg::OP_FIN: begin
        lt_we = 1'b1; lt_wa = slot(v_i, alpha_r); lt_wd = {1'b1, w_i};
        rt_we = 1'b1; rt_wa = slot(w_i, alpha_r); rt_wd = {1'b1, v_i};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lt_we) lt_mem[lt_wa] <= lt_wd;
    if (lt_re) lt_rd_r <= lt_mem[lt_ra];
  end

  always_ff @(posedge clk) begin
    if (rt_we) rt_mem[rt_wa] <= rt_wd;
    if (rt_re) rt_rd_r <= rt_mem[rt_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= 7'd64;
      ccnt_r      <= 7'd64;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == bec_pkg::CFG_VERTEX_COUNT) vcnt_r <= cfg_data;
      if (cfg_we && cfg_index == bec_pkg::CFG_COLOR_COUNT)  ccnt_r <= cfg_data;
      if (cmd.op == bec_pkg::OP_CLR) clr_r <= clr_r + AW'(1);
      if (cmd.op == bec_pkg::OP_EMIT)  out_valid_r <= 1'b1;
      else if (!out_stall)             out_valid_r <= 1'b0;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bec_pkg::OP_LOAD: begin
        act_r <= in_action;
        lv_r  <= in_left_vertex;
        rv_r  <= in_right_vertex;
        rc_r  <= in_read_color;
      end
      bec_pkg::OP_CHECK: begin
        scan_r        <= '0;
        res_color_r   <= '0;
        res_partner_r <= '0;
        res_pvalid_r  <= 1'b0;
        res_edges_r   <= '0;
        if (range_bad) res_status_r <= bec_pkg::ST_RANGE;
        else if (act_r == bec_pkg::ACT_INSERT && nc == '0)
          res_status_r <= bec_pkg::ST_LEFT_FULL;
        else res_status_r <= bec_pkg::ST_OK;
      end
      bec_pkg::OP_RD_RES: begin
        res_pvalid_r <= lt_rd_r[VW];
        if (lt_rd_r[VW]) res_partner_r <= 6'(lt_rd_r[VW-1:0]);
      end
      bec_pkg::OP_LS_CHK: begin
        if (!lt_rd_r[VW]) begin
          alpha_r <= scan_r;
          scan_r  <= '0;
        end else if (sts.scan_last) res_status_r <= bec_pkg::ST_LEFT_FULL;
        else scan_r <= scan_r + CW'(1);
      end
      bec_pkg::OP_RS_CHK: begin
        if (!rt_rd_r[VW]) beta_r <= scan_r;
        else if (sts.scan_last) res_status_r <= bec_pkg::ST_RIGHT_FULL;
        else scan_r <= scan_r + CW'(1);
      end
      bec_pkg::OP_P_ISS: begin
        cur_r     <= w_i;
        at_left_r <= 1'b1;
        steps_r   <= '0;
      end
      bec_pkg::OP_P_LOAD: begin
        nxt_r    <= rt_rd_r[VW-1:0];
        nxt_ok_r <= rt_rd_r[VW];
      end
      bec_pkg::OP_ST_W1: begin
        nn_r    <= nn_src[VW-1:0];
        nn_ok_r <= nn_src[VW];
      end
      bec_pkg::OP_ST_W2: begin
        cur_r     <= nxt_r;
        nxt_r     <= nn_r;
        nxt_ok_r  <= nn_ok_r;
        at_left_r <= !at_left_r;
        steps_r   <= steps_r + SW'(1);
      end
      bec_pkg::OP_FIN: begin
        res_color_r <= 6'(alpha_r);
        res_edges_r <= (steps_r > SW'(255)) ? 8'd255 : 8'(steps_r);
      end
      bec_pkg::OP_EMIT: begin
        out_status_r  <= res_status_r;
        out_color_r   <= res_color_r;
        out_partner_r <= res_partner_r;
        out_pvalid_r  <= res_pvalid_r;
        out_edges_r   <= res_edges_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_assigned_color  = out_color_r;
  assign out_partner         = out_partner_r;
  assign out_partner_valid   = out_pvalid_r;
  assign out_recolored_edges = out_edges_r;

endmodule
`default_nettype wire

// ----- rtl/bipartite_edge_coloring.sv -----
`default_nettype none
// Result time grows with the colors scanned for a full vertex, and with the colors scanned
// on each side and the path edges walked for an insert.
// Throughput: one item at a time; the next beat is taken the cycle after the result is
// queued, later while a held result blocks the result register.
// Rate set by the scans and the path walk (read, two writes and a test per edge).
// Reset: synchronous, active low; then a clearing pass over all MAX_VERTICES*MAX_COLORS table entries, in_stall high.
// ----------------------------------------------------------------------------
// bipartite_edge_coloring
// Edge coloring of a bipartite multigraph by alternating-path color swaps.
// ----------------------------------------------------------------------------
module bipartite_edge_coloring #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_COLORS   = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration writes
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data,
  // item channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_action,
  input  wire logic [5:0] in_left_vertex,
  input  wire logic [5:0] in_right_vertex,
  input  wire logic [5:0] in_read_color,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output logic [5:0]      out_assigned_color,
  output logic [5:0]      out_partner,
  output logic            out_partner_valid,
  output logic [7:0]      out_recolored_edges
);

  // controller drives one datapath op per cycle and follows its status
  bec_pkg::cmd_t cmd;
  bec_pkg::sts_t sts;

  bec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath owns both partner tables and the result register
  bec_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_COLORS   (MAX_COLORS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_action           (in_action),
    .in_left_vertex      (in_left_vertex),
    .in_right_vertex     (in_right_vertex),
    .in_read_color       (in_read_color),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_assigned_color  (out_assigned_color),
    .out_partner         (out_partner),
    .out_partner_valid   (out_partner_valid),
    .out_recolored_edges (out_recolored_edges)
  );

endmodule
`default_nettype wire

// ----- rtl/bec_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bec_checker
// Port-level checks for the edge coloring block.
// ----------------------------------------------------------------------------
module bec_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_status
);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result beat dropped or changed under stall");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while an item is in work");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("not busy after reset");

endmodule

bind bipartite_edge_coloring bec_checker u_bec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status)
);
`default_nettype wire
